@@ design/flha_pkg.sv @@
// Package for the free-list heap allocator: codes, table entry type, FSM states.
// No dependencies; imported by free_list_heap_allocator_top.
`timescale 1ns / 1ps
package flha_pkg;

    // Width of a block start offset or payload byte count (heap up to 65536 bytes)
    localparam int SW = 17;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic          used;
        logic [SW-1:0] start;
        logic [SW-1:0] bytes;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_WR_A,
        S_WR_B,
        S_SHIFT_DN,
        S_FINISH
    } t_state;

endpackage

@@ design/free_list_heap_allocator_top.sv @@
// Free-list heap allocator: block table in one synchronous memory, sequenced scan/shift.
// Depends on flha_pkg.
`timescale 1ns / 1ps
// A request scans the live entries of the block table and decides, then moves the entries
// above the chosen one when an allocation splits a block or on any free, which merges
// free neighbors. The single read port of the block table sets the time taken: every
// entry is read once per scan and once per move. busy stays high while a request runs
// and after reset while the first table entry is written. The result shows for one cycle
// with o_done; it cannot be held off, and a new request may start in that same cycle.
module free_list_heap_allocator_top #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_free_addr,
    output logic        o_done,
    output logic [15:0] o_addr,
    output logic [1:0]  o_status
);
    import flha_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SW:0]   HDR   = (SW+1)'(HEADER_BYTES);
    localparam logic [SW-1:0] INITB = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);

    // Block table memory
    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_entry        mem_wd;

    t_state r_state, n_state;
    logic [1:0]    r_policy;
    logic [CW-1:0] r_count, r_ia, n_ia, r_rix, n_rix, r_pick, n_pick, r_k, n_k;
    logic [CW-1:0] r_newcnt, n_newcnt;
    logic          r_rv, n_rv, r_found, n_found, r_has_next, n_has_next, r_split, n_split;
    logic          r_func, n_func, r_wv, n_wv;
    logic [15:0]   r_req, n_req, r_off, n_off;
    logic [SW-1:0] r_pstart, n_pstart, r_pbytes, n_pbytes, r_best, n_best;
    t_entry        r_last, n_last, r_prev, n_prev, r_next, n_next;
    logic [AW-1:0] r_wa, n_wa;
    logic [1:0]    r_rm, n_rm;
    logic          r_done, n_done;
    logic [15:0]   r_raddr, n_raddr;
    logic [1:0]    r_rstat, n_rstat;

    // Scan compare terms
    logic          fits, match;
    logic [SW:0]   slack_e, slack_p, sum_f;
    logic          pf, nf;
    logic [CW-1:0] tgt;
    t_entry        fent;

    always_comb begin
        fits    = !r_rdata.used && (r_rdata.bytes >= SW'(r_req));
        slack_e = {1'b0, r_rdata.bytes} - (SW+1)'(r_req);
        match   = r_rdata.used && (({1'b0, r_rdata.start} + HDR) == (SW+1)'(r_off));
        slack_p = {1'b0, r_pbytes} - (SW+1)'(r_req);
        pf      = (r_pick != '0) && !r_prev.used;
        nf      = r_has_next && !r_next.used;
        sum_f   = {1'b0, r_pbytes}
                + (pf ? ({1'b0, r_prev.bytes} + HDR) : '0)
                + (nf ? ({1'b0, r_next.bytes} + HDR) : '0);
        tgt     = pf ? (r_pick - CW'(1)) : r_pick;
        fent.used  = 1'b0;
        fent.start = pf ? r_prev.start : r_pstart;
        fent.bytes = sum_f[SW-1:0];
    end

    // Next state and datapath
    always_comb begin
        n_state = r_state;   n_ia = r_ia;       n_rix = r_rix;   n_rv = 1'b0;
        n_pick = r_pick;     n_k = r_k;         n_newcnt = r_newcnt;
        n_found = r_found;   n_has_next = r_has_next;  n_split = r_split;
        n_func = r_func;     n_req = r_req;     n_off = r_off;   n_wv = 1'b0;
        n_pstart = r_pstart; n_pbytes = r_pbytes; n_best = r_best;
        n_last = r_last;     n_prev = r_prev;   n_next = r_next;
        n_wa = r_wa;         n_rm = r_rm;       n_done = 1'b0;
        n_raddr = r_raddr;   n_rstat = r_rstat;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (start) begin
                    n_func = i_func; n_req = i_req_size; n_off = i_free_addr;
                    n_ia = '0; n_found = 1'b0; n_has_next = 1'b0;
                    n_raddr = '0; n_rstat = ST_OK; n_newcnt = r_count;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue reads in order
                if (r_ia < r_count) begin
                    n_rv = 1'b1; n_rix = r_ia; n_ia = r_ia + CW'(1);
                end
                // evaluate returned entry
                if (r_rv) begin
                    n_last = r_rdata;
                    if (r_func == FUNC_ALLOC) begin
                        if (fits) begin
                            if (!r_found) begin
                                n_found = 1'b1; n_pick = r_rix; n_best = slack_e[SW-1:0];
                                n_pstart = r_rdata.start; n_pbytes = r_rdata.bytes;
                            end else if ((r_policy == POL_BEST && slack_e[SW-1:0] < r_best)
                                    || (r_policy == POL_WORST && slack_e[SW-1:0] > r_best)) begin
                                n_pick = r_rix; n_best = slack_e[SW-1:0];
                                n_pstart = r_rdata.start; n_pbytes = r_rdata.bytes;
                            end
                        end
                    end else begin
                        if (!r_found && match) begin
                            n_found = 1'b1; n_pick = r_rix; n_prev = r_last;
                            n_pstart = r_rdata.start; n_pbytes = r_rdata.bytes;
                        end
                        if (r_found && r_rix == r_pick + CW'(1)) begin
                            n_has_next = 1'b1; n_next = r_rdata;
                        end
                    end
                end
                if (r_ia == r_count && !r_rv) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_func == FUNC_ALLOC) begin
                    if (!r_found) begin
                        n_rstat = ST_NOFIT; n_state = S_FINISH;
                    end else if (slack_p >= HDR) begin
                        if (r_count == MAXC) begin
                            n_rstat = ST_FULL; n_state = S_FINISH;
                        end else begin
                            n_split = 1'b1; n_k = r_count - CW'(1);
                            n_newcnt = r_count + CW'(1);
                            n_raddr = 16'({1'b0, r_pstart} + HDR);
                            n_state = S_SHIFT_UP;
                        end
                    end else begin
                        n_split = 1'b0;
                        n_raddr = 16'({1'b0, r_pstart} + HDR);
                        n_state = S_WR_A;
                    end
                end else begin
                    if (!r_found) begin
                        n_rstat = ST_BADFREE; n_state = S_FINISH;
                    end else begin
                        n_rm = 2'(pf) + 2'(nf);
                        n_k = tgt + CW'(1) + CW'(2'(pf) + 2'(nf));
                        n_newcnt = r_count - CW'(2'(pf) + 2'(nf));
                        n_state = S_SHIFT_DN;
                    end
                end
            end
            S_SHIFT_UP: begin
                // move entries above the pick up by one, top first
                if (r_k > r_pick) begin
                    n_wv = 1'b1; n_wa = AW'(r_k + CW'(1)); n_k = r_k - CW'(1);
                end else begin
                    n_state = S_WR_A;
                end
            end
            S_WR_A: n_state = r_split ? S_WR_B : S_FINISH;
            S_WR_B: n_state = S_FINISH;
            S_SHIFT_DN: begin
                // move entries above the merged ones down, bottom first
                if (r_k < r_count) begin
                    n_wv = 1'b1; n_wa = AW'(r_k - CW'(r_rm)); n_k = r_k + CW'(1);
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port and handshake outputs
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wa;
        mem_wd = r_rdata;
        mem_ra = AW'(r_k);
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1; mem_wa = '0;
                mem_wd = '{used: 1'b0, start: '0, bytes: INITB};
            end
            S_SCAN: mem_ra = AW'(r_ia);
            S_SHIFT_UP, S_SHIFT_DN: mem_we = r_wv;
            S_DECIDE: begin
                if (r_func == FUNC_FREE && r_found) begin
                    mem_we = 1'b1; mem_wa = AW'(tgt); mem_wd = fent;
                end
            end
            S_WR_A: begin
                mem_we = 1'b1; mem_wa = AW'(r_pick);
                mem_wd = '{used: 1'b1, start: r_pstart,
                           bytes: r_split ? SW'(r_req) : r_pbytes};
            end
            S_WR_B: begin
                mem_we = 1'b1; mem_wa = AW'(r_pick + CW'(1));
                mem_wd = '{used: 1'b0,
                           start: SW'({1'b0, r_pstart} + HDR + (SW+1)'(r_req)),
                           bytes: SW'(slack_p - HDR)};
            end
            default: mem_we = 1'b0;
        endcase
        busy     = (r_state != S_IDLE);
        o_done   = r_done;
        o_addr   = r_raddr;
        o_status = r_rstat;
    end

    // Block table storage
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_policy <= POL_FIRST;
            r_count <= CW'(1);
            r_rv <= 1'b0;
            r_wv <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv <= n_rv;
            r_wv <= n_wv;
            r_done <= n_done;
            if (i_cfg_we) r_policy <= i_cfg_wdata;
            if (r_state == S_FINISH) r_count <= r_newcnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ia <= n_ia;         r_rix <= n_rix;       r_pick <= n_pick;   r_k <= n_k;
        r_newcnt <= n_newcnt; r_found <= n_found;   r_has_next <= n_has_next;
        r_split <= n_split;   r_func <= n_func;     r_req <= n_req;     r_off <= n_off;
        r_pstart <= n_pstart; r_pbytes <= n_pbytes; r_best <= n_best;
        r_last <= n_last;     r_prev <= n_prev;     r_next <= n_next;
        r_wa <= n_wa;         r_rm <= n_rm;         r_raddr <= n_raddr; r_rstat <= n_rstat;
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MAXC))
        else $error("block count out of range");
    a_done_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside finish");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_addr == 16'd0))
        else $error("error result carries an address");
endmodule
